### rtl/core/tbg_pkg.sv
package tbg_pkg;

   localparam int IDX_W = 10;
   localparam int TBL_N = 624;
   localparam int TBL_M = 397;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TBL_N - 1);

   localparam logic [31:0] MATRIX_A   = 32'h9908b0df;
   localparam logic [31:0] UPPER_MASK = 32'h80000000;
   localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
   localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C   = 32'hefc60000;
   localparam logic [31:0] INIT_MULT  = 32'h6c078965;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BYTE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [31:0] seed;
   } item_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

### rtl/core/tbg_front.sv
module tbg_front
   import tbg_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_operation,
   input  logic [31:0]  req_seed_word,
   input  back_ctl_type ctl,
   output logic         head_valid,
   output item_type     head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             queue_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   logic                 pop;
   item_type             req_item;

   assign req_item.op   = req_operation;
   assign req_item.seed = req_seed_word;

   assign req_stall  = (count_ff == CNT_W'(QUEUE_DEPTH)) | ctl.clearing;
   assign push       = req_valid & ~req_stall;
   assign head_valid = (count_ff != '0);
   assign pop        = ctl.pop & head_valid;
   assign head       = queue_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= req_item;
      end
   end

endmodule

### rtl/core/tbg_back.sv
module tbg_back
   import tbg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  item_type     head,
   output back_ctl_type ctl,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte
);

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_LD_MUL   = 4'd2;
   localparam logic [3:0] ST_LD_WR    = 4'd3;
   localparam logic [3:0] ST_TW_START = 4'd4;
   localparam logic [3:0] ST_TW_FIRST = 4'd5;
   localparam logic [3:0] ST_TW_RD    = 4'd6;
   localparam logic [3:0] ST_TW_WR    = 4'd7;
   localparam logic [3:0] ST_WD_RD    = 4'd8;
   localparam logic [3:0] ST_WD_OUT   = 4'd9;

   logic [31:0]      table_mem [TBL_N];
   logic [31:0]      rd_a_ff, rd_b_ff;

   logic [3:0]       state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [31:0]      cur_ff, cur_in;
   logic [31:0]      seed_ff, seed_in;
   logic [31:0]      prod_ff, prod_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [1:0]       left_ff, left_in;
   logic [23:0]      buf_ff, buf_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;

   logic             wr_en, rd_a_en, rd_b_en;
   logic [IDX_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [31:0]      wr_data;
   logic             out_free;
   logic             pop;

   logic [IDX_W-1:0] k_next;
   logic [IDX_W:0]   k_sum;
   logic [IDX_W-1:0] k_plus_m;
   logic [IDX_W-1:0] slot_next;
   logic [IDX_W-1:0] widx_next;
   logic [31:0]      tw_y;
   logic [31:0]      tw_v;
   logic [31:0]      pmix;
   logic [31:0]      tempered;

   assign k_next    = (k_ff == LAST_SLOT) ? '0 : k_ff + 1'b1;
   assign k_sum     = {1'b0, k_ff} + (IDX_W + 1)'(TBL_M);
   assign k_plus_m  = (k_sum >= (IDX_W + 1)'(TBL_N)) ?
                      IDX_W'(k_sum - (IDX_W + 1)'(TBL_N)) : k_sum[IDX_W-1:0];
   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
   assign widx_next = (widx_ff == LAST_SLOT) ? '0 : widx_ff + 1'b1;

   assign tw_y     = (cur_ff & UPPER_MASK) | (rd_a_ff & LOWER_MASK);
   assign tw_v     = rd_b_ff ^ (tw_y >> 1) ^ (tw_y[0] ? MATRIX_A : 32'h0);
   assign pmix     = rd_a_ff ^ (rd_a_ff >> 30);
   assign tempered = temper(rd_a_ff);

   assign out_free     = ~rsp_valid_ff | ~rsp_stall;
   assign ctl.pop      = pop;
   assign ctl.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      seed_in      = seed_ff;
      prod_in      = prod_ff;
      widx_in      = widx_ff;
      left_in      = left_ff;
      buf_in       = buf_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      wr_en        = 1'b0;
      wr_addr      = k_ff;
      wr_data      = 32'h0;
      rd_a_en      = 1'b0;
      rd_a_addr    = k_ff;
      rd_b_en      = 1'b0;
      rd_b_addr    = k_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = k_ff;
            k_in    = k_next;
            if (k_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               if (head.op == OP_LOAD) begin
                  pop = 1'b1;
                  if (slot_ff == '0) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = head.seed;
                     widx_in = '0;
                     left_in = '0;
                     slot_in = slot_next;
                  end else begin
                     rd_a_en   = 1'b1;
                     rd_a_addr = slot_ff - 1'b1;
                     seed_in   = head.seed;
                     state_in  = ST_LD_MUL;
                  end
               end else if (left_ff != 2'd0) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = buf_ff[7:0];
                     buf_in       = {8'h0, buf_ff[23:8]};
                     left_in      = left_ff - 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  state_in = (widx_ff == '0) ? ST_TW_START : ST_WD_RD;
               end
            end
         end
         ST_LD_MUL: begin
            prod_in  = INIT_MULT * pmix;
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = seed_ff ^ (prod_ff + 32'd1);
            slot_in  = slot_next;
            state_in = ST_IDLE;
         end
         ST_TW_START: begin
            rd_a_en   = 1'b1;
            rd_a_addr = '0;
            k_in      = '0;
            state_in  = ST_TW_FIRST;
         end
         ST_TW_FIRST: begin
            cur_in   = rd_a_ff;
            state_in = ST_TW_RD;
         end
         ST_TW_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = k_next;
            rd_b_en   = 1'b1;
            rd_b_addr = k_plus_m;
            state_in  = ST_TW_WR;
         end
         ST_TW_WR: begin
            wr_en    = 1'b1;
            wr_addr  = k_ff;
            wr_data  = tw_v;
            cur_in   = rd_a_ff;
            k_in     = k_next;
            state_in = (k_ff == LAST_SLOT) ? ST_WD_RD : ST_TW_RD;
         end
         ST_WD_RD: begin
            rd_a_en   = 1'b1;
            rd_a_addr = widx_ff;
            state_in  = ST_WD_OUT;
         end
         ST_WD_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = tempered[7:0];
               buf_in       = tempered[31:8];
               left_in      = 2'd3;
               widx_in      = widx_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         k_ff         <= '0;
         widx_ff      <= '0;
         left_ff      <= '0;
         buf_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         widx_ff      <= widx_in;
         left_ff      <= left_in;
         buf_ff       <= buf_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      seed_ff     <= seed_in;
      prod_ff     <= prod_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= table_mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= table_mem[rd_b_addr];
      end
   end

endmodule

### rtl/core/twister_byte_generator.sv
// mt19937 byte generator, one byte per request
// request channel: req_valid/req_stall with req_operation and req_seed_word.
//   a load request writes req_seed_word into the next table slot (slot 0 as is,
//   later slots mixed with the init recurrence of the slot before); a byte
//   request returns one byte on the response channel, loads return nothing
// response channel: rsp_valid/rsp_stall with rsp_out_byte, held in an output
//   register; bytes of each tempered word come out least significant first
// requests pass a QUEUE_DEPTH-entry queue (two entries by default), so a
//   request is taken while the engine or the response side is busy
// a buffered byte comes straight from the held word; a new word is read from
//   the table and tempered, after a twist of the whole table when the word
//   index is back at 0, using the dual-read table memory; a load writes slot 0
//   directly and a later slot in steps: read, multiply, write
// a full table pass gives 2496 bytes
// after reset the table memory is cleared, one word a cycle over all 624
//   slots, with req_stall high throughout
// a stalled response holds its byte; the engine waits for the output
//   register while the queue keeps taking requests until full
module twister_byte_generator
   import tbg_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_seed_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte
);

   back_ctl_type ctl;
   item_type     head;
   logic         head_valid;

   tbg_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_seed_word (req_seed_word),
      .ctl           (ctl),
      .head_valid    (head_valid),
      .head          (head)
   );

   tbg_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .ctl          (ctl),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

### rtl/core/tbg_checker.sv
module tbg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte
);

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // table clear keeps requests out after reset
   assert property (@(posedge clock) reset |=> req_stall ##1 req_stall)
      else $error("request taken during table clear");

   // no byte can appear while the clear is still running
   assert property (@(posedge clock) reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response during table clear");

   // stalled response keeps its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled response changed");

   // stalled request stays valid
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("stalled request dropped");

endmodule

bind twister_byte_generator tbg_checker u_tbg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte)
);

### test/tb.sv
`timescale 1ns / 100ps

module tb
   import tbg_pkg::*;
();

   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PERCENT = 9;
   localparam int RANDOM_ITEMS = 160;
   localparam int LONG_PASS_BYTES = 140;

   class byte_scoreboard;
      logic [31:0] state_words [TBL_N];
      int unsigned word_ptr;
      int unsigned slot_ptr;
      logic [1:0]  bytes_held;
      logic [23:0] held_bytes;
      logic [7:0]  expected_bytes [$];
      int          failures;

      function new();
         foreach (state_words[k]) state_words[k] = '0;
         word_ptr = 0;
         slot_ptr = 0;
         bytes_held = '0;
         held_bytes = '0;
         failures = 0;
      endfunction

      function void twist_state();
         logic [31:0] joined;
         logic [31:0] next_word;
         for (int k = 0; k < TBL_N; k++) begin
            joined = (state_words[k] & UPPER_MASK) |
                     (state_words[(k + 1) % TBL_N] & LOWER_MASK);
            next_word = state_words[(k + TBL_M) % TBL_N] ^ (joined >> 1);
            if (joined[0]) begin
               next_word = next_word ^ MATRIX_A;
            end
            state_words[k] = next_word;
         end
      endfunction

      function logic [31:0] tempered(logic [31:0] raw);
         logic [31:0] t;
         t = raw ^ {11'b0, raw[31:11]};
         t = t ^ ({t[24:0], 7'b0} & TEMPER_B);
         t = t ^ ({t[16:0], 15'b0} & TEMPER_C);
         t = t ^ {18'b0, t[31:18]};
         return t;
      endfunction

      function void note_request(logic op, logic [31:0] seed);
         logic [31:0] prev;
         logic [31:0] word;
         if (op == OP_LOAD) begin
            if (slot_ptr == 0) begin
               state_words[0] = seed;
               word_ptr = 0;
               bytes_held = '0;
            end else begin
               prev = state_words[slot_ptr - 1];
               state_words[slot_ptr] = seed ^ (INIT_MULT * (prev ^ (prev >> 30)) + 32'd1);
            end
            slot_ptr = (slot_ptr + 1) % TBL_N;
         end else if (bytes_held == 0) begin
            if (word_ptr == 0) begin
               twist_state();
            end
            word = tempered(state_words[word_ptr]);
            word_ptr = (word_ptr + 1) % TBL_N;
            bytes_held = 2'd3;
            held_bytes = word[31:8];
            expected_bytes.push_back(word[7:0]);
         end else begin
            bytes_held = bytes_held - 2'd1;
            expected_bytes.push_back(held_bytes[7:0]);
            held_bytes = held_bytes >> 8;
         end
      endfunction

      function void check_byte(logic [7:0] actual);
         logic [7:0] expected;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte, expected none, actual %02h", $time, actual);
            failures++;
         end else begin
            expected = expected_bytes.pop_front();
            if (actual !== expected) begin
               $display("%0t: byte mismatch, expected %02h, actual %02h",
                        $time, expected, actual);
               failures++;
            end
         end
      endfunction

      function void check_leftovers();
         if (expected_bytes.size() != 0) begin
            $display("%0t: %0d bytes never returned, expected %02h, actual none",
                     $time, expected_bytes.size(), expected_bytes[0]);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_LOAD;
   logic [31:0] req_seed_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;

   logic        calm = 1'b0;
   int unsigned cycles = 0;

   byte_scoreboard sb = new();

   twister_byte_generator DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_seed_word (req_seed_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_byte(rsp_out_byte);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // seed words: a fixed pattern, zero, all ones, 1 to 3 random bytes repeated cyclically, else random
   function automatic logic [31:0] random_seed();
      logic [31:0] word;
      logic [7:0]  seed_bytes [3];
      int unsigned seed_len;
      word = '0;
      case ($urandom_range(0, 15))
         0: word = 32'h30303030;
         1: word = '0;
         2: word = '1;
         3, 4: begin
            seed_len = $urandom_range(1, 3);
            foreach (seed_bytes[k]) seed_bytes[k] = 8'($urandom);
            for (int k = 0; k < 4; k++) word[8*k +: 8] = seed_bytes[k % seed_len];
         end
         default: word = $urandom;
      endcase
      return word;
   endfunction

   task automatic send_request(input logic op, input logic [31:0] seed);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         req_operation <= 1'($urandom);
         req_seed_word <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_seed_word <= seed;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, seed);
   endtask

   task automatic send_bytes(input int count);
      repeat (count) send_request(OP_BYTE, $urandom);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_bytes.size() != 0);
   endtask

   initial begin
      int items;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // unseeded table gives zeros
      send_bytes(4);
      send_request(OP_LOAD, 32'hffffffff);
      send_request(OP_LOAD, 32'h00000000);
      send_request(OP_LOAD, 32'h30303030);
      send_request(OP_LOAD, 32'h78563412);
      send_bytes(3);
      // later slot loaded mid-word
      send_request(OP_LOAD, 32'h80000000);
      send_bytes(3);
      send_request(OP_LOAD, 32'h7fffffff);
      send_request(OP_LOAD, 32'h00000001);
      send_bytes(5);
      hold_until_drained();

      // full seed pass and slot wrap, then a reseeded run
      calm <= 1'b1;
      while (sb.slot_ptr != 0) send_request(OP_LOAD, random_seed());
      send_bytes(5);
      send_request(OP_LOAD, random_seed());
      repeat (3) send_request(OP_LOAD, random_seed());
      for (int k = 0; k < LONG_PASS_BYTES; k++) begin
         if (k == 60) begin
            calm <= 1'b0;
         end
         if ($urandom_range(0, 99) < 4) begin
            send_request(OP_LOAD, random_seed());
         end
         send_request(OP_BYTE, $urandom);
      end
      hold_until_drained();

      items = 0;
      while (items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            for (int n = $urandom_range(1, 8); n > 0; n--) begin
               send_request(OP_LOAD, random_seed());
               items++;
            end
            for (int n = $urandom_range(4, 40); n > 0; n--) begin
               send_request(OP_BYTE, $urandom);
               items++;
            end
         end else begin
            for (int n = $urandom_range(1, 10); n > 0; n--) begin
               send_request(1'($urandom), random_seed());
               items++;
            end
         end
      end
      hold_until_drained();
      repeat (50) @(posedge clock);
      sb.check_leftovers();

      if (sb.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
